@@ rtl/core/ofifo_pkg.sv @@
// Shared types and constants for the overwriting ring FIFO.
package ofifo_pkg;

    // Fixed field widths of the request and response words
    localparam int KIND_W = 2;
    localparam int DATA_W = 32;
    localparam int CNT_W  = 5;

    // Capacity register value after reset
    localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

    // Most response words a single batch read may produce
    localparam logic [CNT_W-1:0] RESULT_LIMIT = 5'd16;

    // Request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_BATCH = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    // Sequencer states
    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_FETCH = 1'b1
    } state_t;

    // One response word as it travels from the sequencer to the output buffer
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              item_valid;
        logic              last;
        logic              status;
        logic              overwrote;
        logic [CNT_W-1:0]  fill_count;
        logic              is_empty;
        logic              is_full;
    } res_t;

endpackage

@@ rtl/core/ofifo_in_if.sv @@
// Request channel: valid/ready handshake with the request payload.
interface ofifo_in_if;
    import ofifo_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] write_data;
    logic [CNT_W-1:0]  batch_max;

    modport source (output valid, output kind, output write_data, output batch_max,
                    input ready);
    modport sink   (input valid, input kind, input write_data, input batch_max,
                    output ready);
endinterface

@@ rtl/core/ofifo_out_if.sv @@
// Response channel: valid/ready handshake with the response payload.
interface ofifo_out_if;
    import ofifo_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              item_valid;
    logic              last;
    logic              status;
    logic              overwrote;
    logic [CNT_W-1:0]  fill_count;
    logic              is_empty;
    logic              is_full;

    modport source (output valid, output read_data, output item_valid, output last,
                    output status, output overwrote, output fill_count,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input read_data, input item_valid, input last,
                    input status, input overwrote, input fill_count,
                    input is_empty, input is_full, output ready);
endinterface

@@ rtl/core/overwriting_ring_fifo_top.sv @@
// Overwriting ring FIFO: top level with entry RAM, sequencer and output buffer.
//
// A circular FIFO of up to DEPTH entries whose usable size is the capacity
// register (0 acts as 1, values above DEPTH act as DEPTH). Requests are write,
// read one, batch read and clear; a write to a full ring replaces the oldest
// entry and reports overwrote. Writing the capacity register also empties the
// ring. Write, clear, a read of an empty ring and a batch that finds nothing
// are answered with a single word at acceptance. A read or a batch first issues
// the read to the entry RAM, whose single read port with registered read data
// then delivers one word per cycle while the output buffer has room, and the
// request port is held off meanwhile. A two-word output buffer lets the next
// request in while a response word still waits. Every response word carries
// the fill count, empty and full after the whole request. There is no clearing
// pass after reset; entries read only after they are written.
module overwriting_ring_fifo_top #(
    parameter int DEPTH      = 16,
    parameter int ITEM_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [ofifo_pkg::CNT_W-1:0] cfg_wdata,
    ofifo_in_if.sink                    req,
    ofifo_out_if.source                 rsp
);
    import ofifo_pkg::*;

    localparam int STORE_W = (ITEM_WIDTH < DATA_W) ? ITEM_WIDTH : DATA_W;
    localparam int PTR_W   = $clog2(DEPTH);

    logic               push;
    res_t               push_res;
    res_t               out_res;
    logic               buf_full;
    logic               ram_we;
    logic [PTR_W-1:0]   ram_waddr;
    logic [STORE_W-1:0] ram_wdata;
    logic               ram_re;
    logic [PTR_W-1:0]   ram_raddr;
    logic [STORE_W-1:0] ram_rdata;

    // Entry store
    ofifo_ram #(
        .WIDTH (STORE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Pointer and count sequencer
    ofifo_ctrl #(
        .DEPTH   (DEPTH),
        .STORE_W (STORE_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_kind   (req.kind),
        .in_wdata  (req.write_data),
        .in_max    (req.batch_max),
        .slot_free (!buf_full),
        .push      (push),
        .res       (push_res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // Response buffer
    ofifo_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_res  (push_res),
        .full      (buf_full),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_res   (out_res)
    );

    // Response payload
    assign rsp.read_data  = out_res.read_data;
    assign rsp.item_valid = out_res.item_valid;
    assign rsp.last       = out_res.last;
    assign rsp.status     = out_res.status;
    assign rsp.overwrote  = out_res.overwrote;
    assign rsp.fill_count = out_res.fill_count;
    assign rsp.is_empty   = out_res.is_empty;
    assign rsp.is_full    = out_res.is_full;

    // A word is never pushed into a full buffer
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !buf_full)
        else $error("response pushed into full output buffer");

    // An overwrite leaves the ring full
    a_overwrite_full: assert property (@(posedge clk) disable iff (!rst_n)
        push && push_res.overwrote |-> push_res.is_full)
        else $error("overwrite without full ring");

    // Words without an item close their request and carry zero data
    a_noitem_last: assert property (@(posedge clk) disable iff (!rst_n)
        push && !push_res.item_valid |-> push_res.last && (push_res.read_data == '0))
        else $error("non-item word not last or data not zero");

    // Requests are held off while a read is in flight
    a_hold_off: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re && !(req.valid && req.ready) |-> !req.ready)
        else $error("request accepted during a RAM read");

endmodule

@@ rtl/core/ofifo_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module ofifo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/ofifo_ctrl.sv @@
// Ring sequencer: pointers, fill count, capacity register and RAM access.
module ofifo_ctrl #(
    parameter int DEPTH   = 16,
    parameter int STORE_W = 32,
    localparam int PTR_W  = $clog2(DEPTH)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // capacity register write
    input  logic                          cfg_we,
    input  logic [ofifo_pkg::CNT_W-1:0]   cfg_wdata,
    // request side
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ofifo_pkg::KIND_W-1:0]  in_kind,
    input  logic [ofifo_pkg::DATA_W-1:0]  in_wdata,
    input  logic [ofifo_pkg::CNT_W-1:0]   in_max,
    // response side
    input  logic                          slot_free,
    output logic                          push,
    output ofifo_pkg::res_t               res,
    // entry RAM
    output logic                          ram_we,
    output logic [PTR_W-1:0]              ram_waddr,
    output logic [STORE_W-1:0]            ram_wdata,
    output logic                          ram_re,
    output logic [PTR_W-1:0]              ram_raddr,
    input  logic [STORE_W-1:0]            ram_rdata
);
    import ofifo_pkg::*;

    localparam int AW      = (PTR_W + 1 > CNT_W) ? PTR_W + 1 : CNT_W;
    localparam int CAP_TOP = (DEPTH < (1 << CNT_W) - 1) ? DEPTH : (1 << CNT_W) - 1;
    localparam logic [CNT_W-1:0] CAP_MAX = CAP_TOP[CNT_W-1:0];

    state_t             state_reg,  state_next;
    logic [PTR_W-1:0]   head_reg,   head_next;
    logic [PTR_W-1:0]   tail_reg,   tail_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic [CNT_W-1:0]   remain_reg, remain_next;
    logic [CNT_W-1:0]   cap_reg;

    logic [CNT_W-1:0]   eff_cap;
    logic               ring_full;
    logic [CNT_W-1:0]   take;
    logic [CNT_W-1:0]   wr_count;
    logic               accept;
    logic               fetch_start;
    kind_t              kind;

    // Pointer step with compare-and-subtract wrap
    function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p,
                                              input logic [CNT_W-1:0] cap);
        logic [AW-1:0] n;
        logic [AW-1:0] c;
        n = AW'(p) + AW'(1);
        c = AW'(cap);
        if (n >= c)
        begin
            n = n - c;
        end
        if (n >= c)
        begin
            n = '0;
        end
        return n[PTR_W-1:0];
    endfunction

    // Pack one response word; flags follow the given count
    function automatic res_t make_res(input logic [DATA_W-1:0] d,
                                      input logic v,
                                      input logic l,
                                      input logic s,
                                      input logic o,
                                      input logic [CNT_W-1:0] cnt,
                                      input logic [CNT_W-1:0] cap);
        res_t r;
        r.read_data  = d;
        r.item_valid = v;
        r.last       = l;
        r.status     = s;
        r.overwrote  = o;
        r.fill_count = cnt;
        r.is_empty   = (cnt == '0);
        r.is_full    = (cnt == cap);
        return r;
    endfunction

    // Effective capacity: zero acts as one, clipped to the RAM depth
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CNT_W'(1);
        end
        else if (cap_reg > CAP_MAX)
        begin
            eff_cap = CAP_MAX;
        end
        else
        begin
            eff_cap = cap_reg;
        end
    end

    // Batch size: min(requested, held, limit)
    always_comb
    begin
        take = (in_max < count_reg) ? in_max : count_reg;
        if (take > RESULT_LIMIT)
        begin
            take = RESULT_LIMIT;
        end
    end

    assign kind      = kind_t'(in_kind);
    assign ring_full = (count_reg >= eff_cap);
    assign wr_count  = ring_full ? eff_cap : count_reg + CNT_W'(1);
    assign in_ready  = (state_reg == ST_IDLE) && slot_free;
    assign accept    = in_valid && in_ready;
    assign fetch_start = ((kind == KIND_READ) && (count_reg != '0)) ||
                         ((kind == KIND_BATCH) && (take != '0));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && fetch_start)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                if (slot_free && (remain_reg == CNT_W'(1)))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, RAM access and response words
    always_comb
    begin
        push        = 1'b0;
        res         = make_res('0, 1'b0, 1'b1, 1'b0, 1'b0, count_reg, eff_cap);
        ram_we      = 1'b0;
        ram_waddr   = tail_reg;
        ram_wdata   = in_wdata[STORE_W-1:0];
        ram_re      = 1'b0;
        ram_raddr   = head_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        remain_next = remain_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        KIND_WRITE:
                        begin
                            // full ring: replace the oldest entry
                            ram_we     = 1'b1;
                            push       = 1'b1;
                            count_next = wr_count;
                            tail_next  = adv(tail_reg, eff_cap);
                            if (ring_full)
                            begin
                                ram_waddr = head_reg;
                                head_next = adv(head_reg, eff_cap);
                            end
                            res = make_res('0, 1'b0, 1'b1, 1'b0, ring_full,
                                           wr_count, eff_cap);
                        end
                        KIND_READ:
                        begin
                            if (count_reg == '0)
                            begin
                                push = 1'b1;
                                res  = make_res('0, 1'b0, 1'b1, 1'b1, 1'b0,
                                                count_reg, eff_cap);
                            end
                            else
                            begin
                                ram_re      = 1'b1;
                                head_next   = adv(head_reg, eff_cap);
                                count_next  = count_reg - CNT_W'(1);
                                remain_next = CNT_W'(1);
                            end
                        end
                        KIND_BATCH:
                        begin
                            if (take == '0)
                            begin
                                push = 1'b1;
                            end
                            else
                            begin
                                ram_re      = 1'b1;
                                head_next   = adv(head_reg, eff_cap);
                                count_next  = count_reg - take;
                                remain_next = take;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            push       = 1'b1;
                            head_next  = '0;
                            tail_next  = '0;
                            count_next = '0;
                            res = make_res('0, 1'b0, 1'b1, 1'b0, 1'b0, '0, eff_cap);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FETCH:
            begin
                // emit the word held on the RAM read port, fetch the next one behind it
                if (slot_free)
                begin
                    push        = 1'b1;
                    remain_next = remain_reg - CNT_W'(1);
                    res = make_res(DATA_W'(ram_rdata), 1'b1, remain_reg == CNT_W'(1),
                                   1'b0, 1'b0, count_reg, eff_cap);
                    if (remain_reg != CNT_W'(1))
                    begin
                        ram_re    = 1'b1;
                        head_next = adv(head_reg, eff_cap);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // State registers; a capacity write also empties the ring
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            remain_reg <= '0;
            cap_reg    <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            cap_reg   <= cfg_wdata;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
        end
    end

endmodule

@@ rtl/core/ofifo_obuf.sv @@
// Two-word output buffer between the sequencer and the response channel.
module ofifo_obuf (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ofifo_pkg::res_t push_res,
    output logic            full,
    output logic            out_valid,
    input  logic            out_ready,
    output ofifo_pkg::res_t out_res
);
    import ofifo_pkg::*;

    res_t       data0_reg, data0_next;
    res_t       data1_reg, data1_next;
    logic [1:0] cnt_reg,   cnt_next;
    logic       pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign full      = (cnt_reg == 2'd2);
    assign pop       = out_valid && out_ready;
    assign out_res   = data0_reg;

    // Shift on pop, fill the first free slot on push
    always_comb
    begin
        data0_next = data0_reg;
        data1_next = data1_reg;
        cnt_next   = cnt_reg;
        if (pop && push)
        begin
            if (cnt_reg == 2'd1)
            begin
                data0_next = push_res;
            end
            else
            begin
                data0_next = data1_reg;
                data1_next = push_res;
            end
        end
        else if (pop)
        begin
            data0_next = data1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
        else if (push)
        begin
            if (cnt_reg == 2'd0)
            begin
                data0_next = push_res;
            end
            else
            begin
                data1_next = push_res;
            end
            cnt_next = cnt_reg + 2'd1;
        end
    end

    // Word count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Payload slots
    always_ff @(posedge clk)
    begin
        data0_reg <= data0_next;
        data1_reg <= data1_next;
    end

endmodule
